// ----- sv/assert_macros.svh -----
// Assertion macros shared by the point conversion RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold on every clock out of reset.
`define C2S_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Implication checked on every clock out of reset.
`define C2S_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define C2S_ASSERT(lbl, clk, rstn, prop, msg)
`define C2S_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- sv/c2s_pkg.sv -----
// Shared types and constants of the cartesian to spherical point unit.
`default_nettype none
package c2s_pkg;
    // CORDIC geometry
    localparam int ITERS     = 26;
    localparam int ANG_SHIFT = 12;
    localparam int ANG_W     = 28;
    localparam int CW        = 57;
    localparam int FRAC_TOP  = 52;
    localparam int GAIN_FRAC = 40;
    localparam int G_LO_W    = 21;
    localparam logic [63:0] GAIN_Q40 = 64'd1810632051964;

    // angles in 1/4096 centidegree
    localparam logic signed [ANG_W-1:0] ANG_45  = 28'sd18432000;
    localparam logic signed [ANG_W-1:0] ANG_90  = 28'sd36864000;
    localparam logic [ANG_W-1:0]        ANG_180 = 28'd73728000;
    localparam logic [ANG_W-1:0]        ANG_360 = 28'd147456000;

    // atan(2^-i) in 1/4096 centidegree
    localparam logic signed [ANG_W-1:0] ATAN_TAB [ITERS] = '{
        18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663,
        183343, 91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358,
        179, 90, 45, 22, 11, 6, 3, 1, 1
    };

    // result fields
    localparam int ELEV_W = 15;
    localparam int AZ_W   = 16;
    localparam int RNG_W  = 16;
    localparam logic signed [ELEV_W-1:0] ELEV_LIMIT = 15'sd9000;
    localparam logic [AZ_W-1:0]          AZ_MAX     = 16'd35999;

    // range divide by ten: clamp then reciprocal multiply
    localparam int          DIV_IN_W    = 20;
    localparam int          DIV10_SHIFT = 35;
    localparam logic [31:0] DIV10_MUL   = 32'hCCCCCCCD;
    localparam logic [31:0] RNG_CLAMP   = 32'd655359;

    // decoupling queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // per-point classification
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic z_neg;
        logic origin;
    } c2s_flags_t;
    localparam int FLAGS_W = $bits(c2s_flags_t);
endpackage
`default_nettype wire

// ----- sv/c2s_front.sv -----
// Input stage: takes a point beat, folds signs and classifies it for the queue.
`default_nettype none
module c2s_front #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          s_valid,
    output logic                                               s_ready,
    input  wire logic signed [COORD_BITS-1:0]                  x_mm,
    input  wire logic signed [COORD_BITS-1:0]                  y_mm,
    input  wire logic signed [COORD_BITS-1:0]                  z_mm,
    input  wire logic                                          q_full,
    output logic                                               q_push,
    output logic [3*COORD_BITS+c2s_pkg::FLAGS_W-1:0]          q_data
);
    logic                  fv_reg, fv_next;
    logic [COORD_BITS-1:0] ax_reg, ay_reg, az_reg;
    c2s_pkg::c2s_flags_t   fl_reg, fl_next;
    logic                  take;

    assign q_push  = fv_reg && !q_full;
    assign s_ready = !fv_reg || !q_full;
    assign take    = s_valid && s_ready;

    // sign and origin classification
    always_comb begin
        fl_next.x_neg  = x_mm[COORD_BITS-1];
        fl_next.y_neg  = y_mm[COORD_BITS-1];
        fl_next.z_neg  = z_mm[COORD_BITS-1];
        fl_next.origin = (x_mm == '0) && (y_mm == '0) && (z_mm == '0);
        fv_next = take ? 1'b1 : (q_push ? 1'b0 : fv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
    end

    // magnitudes; the most negative value maps onto its unsigned magnitude
    always_ff @(posedge aclk) begin
        if (take) begin
            ax_reg <= x_mm[COORD_BITS-1] ? (~x_mm + 1'b1) : x_mm;
            ay_reg <= y_mm[COORD_BITS-1] ? (~y_mm + 1'b1) : y_mm;
            az_reg <= z_mm[COORD_BITS-1] ? (~z_mm + 1'b1) : z_mm;
            fl_reg <= fl_next;
        end
    end

    assign q_data = {fl_reg, az_reg, ay_reg, ax_reg};
endmodule
`default_nettype wire

// ----- sv/c2s_fifo.sv -----
// Short queue between the classify stage and the conversion pipeline.
`default_nettype none
`include "assert_macros.svh"
module c2s_fifo #(
    parameter int W = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              full,
    output logic              empty
);
    logic [W-1:0]             mem [c2s_pkg::Q_DEPTH];
    logic [c2s_pkg::Q_AW-1:0] wp_reg, rp_reg;
    logic [c2s_pkg::Q_AW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (c2s_pkg::Q_AW+1)'(c2s_pkg::Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rp_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= wdata;
        end
    end

    `C2S_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, !full || pop, "queue write while full")
    `C2S_ASSERT_IMP(a_no_underflow, aclk, aresetn, pop, !empty, "queue read while empty")
    `C2S_ASSERT(a_count_bound, aclk, aresetn, cnt_reg <= (c2s_pkg::Q_AW+1)'(c2s_pkg::Q_DEPTH), "queue count out of range")
endmodule
`default_nettype wire

// ----- sv/c2s_cordic.sv -----
// One first-quadrant CORDIC vectoring pass, one iteration per pipeline stage.
`default_nettype none
module c2s_cordic (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [c2s_pkg::CW-1:0]       x_in,
    input  wire logic signed [c2s_pkg::CW-1:0]       y_in,
    output logic [c2s_pkg::ANG_W-1:0]                angle,
    output logic signed [c2s_pkg::CW-1:0]            mag
);
    localparam int N  = c2s_pkg::ITERS;
    localparam int DW = c2s_pkg::CW;
    localparam int AW = c2s_pkg::ANG_W;

    typedef struct packed {
        logic yzero;
        logic xzero;
        logic equal;
    } spec_t;

    logic signed [DW-1:0] x_reg [N];
    logic signed [DW-1:0] y_reg [N];
    logic signed [AW-1:0] a_reg [N];
    spec_t                sp_reg [N];
    logic [AW-1:0]        angle_reg, angle_next;
    logic signed [DW-1:0] mag_reg;

    // rotation stages
    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [DW-1:0] xp, yp;
        logic signed [AW-1:0] ap;
        spec_t                sp;
        if (i == 0) begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign ap = '0;
            assign sp = '{yzero: (y_in == '0), xzero: (x_in == '0), equal: (x_in == y_in)};
        end else begin : g_next
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign ap = a_reg[i-1];
            assign sp = sp_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (yp > 0) begin
                    x_reg[i] <= xp + (yp >>> i);
                    y_reg[i] <= yp - (xp >>> i);
                    a_reg[i] <= ap + c2s_pkg::ATAN_TAB[i];
                end else begin
                    x_reg[i] <= xp - (yp >>> i);
                    y_reg[i] <= yp + (xp >>> i);
                    a_reg[i] <= ap - c2s_pkg::ATAN_TAB[i];
                end
                sp_reg[i] <= sp;
            end
        end
    end

    // exact axis and diagonal cases, then clamp to a quarter turn
    always_comb begin
        if (sp_reg[N-1].yzero) begin
            angle_next = '0;
        end else if (sp_reg[N-1].xzero) begin
            angle_next = c2s_pkg::ANG_90;
        end else if (sp_reg[N-1].equal) begin
            angle_next = c2s_pkg::ANG_45;
        end else if (a_reg[N-1] < 0) begin
            angle_next = '0;
        end else if (a_reg[N-1] > c2s_pkg::ANG_90) begin
            angle_next = c2s_pkg::ANG_90;
        end else begin
            angle_next = a_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
            mag_reg   <= x_reg[N-1];
        end
    end

    assign angle = angle_reg;
    assign mag   = mag_reg;
endmodule
`default_nettype wire

// ----- sv/c2s_range.sv -----
// Range path: sum of squares, pipelined bitwise square root, divide by ten.
`default_nettype none
module c2s_range #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [COORD_BITS-1:0]        ax,
    input  wire logic [COORD_BITS-1:0]        ay,
    input  wire logic [COORD_BITS-1:0]        az,
    output logic [c2s_pkg::RNG_W-1:0]         rng
);
    localparam int C  = COORD_BITS;
    localparam int SW = 2*COORD_BITS;
    localparam int RW = COORD_BITS+2;
    localparam int PW = c2s_pkg::DIV_IN_W + 32;

    logic [SW-1:0] sqx_reg, sqy_reg, sqz_reg, sum_reg;
    logic [RW-1:0] rem_reg  [C];
    logic [C-1:0]  root_reg [C];
    logic [SW-1:0] val_reg  [C];
    logic [31:0]   s32;
    logic [c2s_pkg::DIV_IN_W-1:0] sc;
    logic [PW-1:0] prod_reg;
    logic [c2s_pkg::RNG_W-1:0] rng_reg;

    // squares, then their sum
    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            sqz_reg <= az * az;
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
        end
    end

    // one root bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < C; k++) begin : g_root
        logic [RW-1:0] rin, rtry, trial;
        logic [C-1:0]  qin;
        logic [SW-1:0] vin;
        if (k == 0) begin : g_first
            assign rin = '0;
            assign qin = '0;
            assign vin = sum_reg;
        end else begin : g_next
            assign rin = rem_reg[k-1];
            assign qin = root_reg[k-1];
            assign vin = val_reg[k-1];
        end
        assign rtry  = {rin[RW-3:0], vin[SW-1:SW-2]};
        assign trial = {qin, 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rtry >= trial) begin
                    rem_reg[k]  <= rtry - trial;
                    root_reg[k] <= {qin[C-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rtry;
                    root_reg[k] <= {qin[C-2:0], 1'b0};
                end
                val_reg[k] <= {vin[SW-3:0], 2'b00};
            end
        end
    end

    // clamp keeps the quotient at or below full scale
    assign s32 = 32'(root_reg[C-1]);
    assign sc  = (s32 > c2s_pkg::RNG_CLAMP) ? c2s_pkg::RNG_CLAMP[c2s_pkg::DIV_IN_W-1:0]
                                            : s32[c2s_pkg::DIV_IN_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(sc) * PW'(c2s_pkg::DIV10_MUL);
            rng_reg  <= prod_reg[c2s_pkg::DIV10_SHIFT +: c2s_pkg::RNG_W];
        end
    end

    assign rng = rng_reg;
endmodule
`default_nettype wire

// ----- sv/c2s_back.sv -----
// Conversion pipeline: two CORDIC passes, range path, quadrant fold, output register.
`default_nettype none
`include "assert_macros.svh"
module c2s_back #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      q_empty,
    input  wire logic [3*COORD_BITS+c2s_pkg::FLAGS_W-1:0]  q_data,
    output logic                                           q_pop,
    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output logic signed [c2s_pkg::ELEV_W-1:0]              m_elev,
    output logic [c2s_pkg::AZ_W-1:0]                       m_azim,
    output logic [c2s_pkg::RNG_W-1:0]                      m_rng
);
    localparam int C      = COORD_BITS;
    localparam int DW     = c2s_pkg::CW;
    localparam int FRAC   = c2s_pkg::FRAC_TOP - COORD_BITS;
    localparam int CL     = c2s_pkg::ITERS + 1;
    localparam int RL     = COORD_BITS + 4;
    localparam int OUT_K  = 2*CL;
    localparam int RD     = OUT_K - RL;
    localparam int LW     = c2s_pkg::G_LO_W;
    localparam logic [63:0] GAIN_F = c2s_pkg::GAIN_Q40 >> (c2s_pkg::GAIN_FRAC - FRAC);
    localparam logic [LW-1:0] G_LO = GAIN_F[LW-1:0];
    localparam logic [LW-1:0] G_HI = GAIN_F[2*LW-1:LW];

    logic                 adv;
    logic                 vld_reg [OUT_K+1];
    logic                 mv_reg;
    logic [C-1:0]         ax0_reg, ay0_reg, az0_reg;
    c2s_pkg::c2s_flags_t  fl_reg [OUT_K+1];
    logic signed [DW-1:0] h0, y0, hyp;
    logic [c2s_pkg::ANG_W-1:0] t_azim, t_elev, azi;
    logic [DW-1:0]        plo_reg, phi_reg;
    logic signed [DW-1:0] zk_dly [CL-1];
    logic [c2s_pkg::RNG_W-1:0] rng_raw;
    logic [c2s_pkg::RNG_W-1:0] rng_dly [RD];
    logic [c2s_pkg::AZ_W-1:0]  az_dly [CL];
    logic [c2s_pkg::AZ_W-1:0]  azc;
    logic signed [c2s_pkg::ELEV_W-1:0] elc;
    c2s_pkg::c2s_flags_t  fa, fo;
    logic signed [c2s_pkg::ELEV_W-1:0] elev_reg;
    logic [c2s_pkg::AZ_W-1:0]  azim_reg;
    logic [c2s_pkg::RNG_W-1:0] rng_reg;

    // whole pipeline moves when the output register is free or drained
    assign adv   = !mv_reg || m_ready;
    assign q_pop = adv && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= OUT_K; k++) begin
                vld_reg[k] <= 1'b0;
            end
            mv_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= q_pop;
            for (int k = 1; k <= OUT_K; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            mv_reg <= vld_reg[OUT_K];
        end
    end

    // entry stage and flag line
    always_ff @(posedge aclk) begin
        if (adv) begin
            ax0_reg   <= q_data[C-1:0];
            ay0_reg   <= q_data[2*C-1:C];
            az0_reg   <= q_data[3*C-1:2*C];
            fl_reg[0] <= q_data[3*C +: c2s_pkg::FLAGS_W];
            for (int k = 1; k <= OUT_K; k++) begin
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    end

    // azimuth pass, leaves the scaled horizontal distance
    assign h0 = DW'(ax0_reg) << FRAC;
    assign y0 = DW'(ay0_reg) << FRAC;

    c2s_cordic u_azim (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (h0),
        .y_in  (y0),
        .angle (t_azim),
        .mag   (hyp)
    );

    c2s_range #(.COORD_BITS(COORD_BITS)) u_range (
        .aclk (aclk),
        .en   (adv),
        .ax   (ax0_reg),
        .ay   (ay0_reg),
        .az   (az0_reg),
        .rng  (rng_raw)
    );

    // |z| times the CORDIC gain, split in two partial products
    always_ff @(posedge aclk) begin
        if (adv) begin
            plo_reg   <= DW'(az0_reg) * DW'(G_LO);
            phi_reg   <= DW'(az0_reg) * DW'(G_HI);
            zk_dly[0] <= plo_reg + (phi_reg << LW);
            for (int j = 1; j < CL-1; j++) begin
                zk_dly[j] <= zk_dly[j-1];
            end
        end
    end

    // elevation pass against the horizontal distance
    c2s_cordic u_elev (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (hyp),
        .y_in  (zk_dly[CL-2]),
        .angle (t_elev),
        .mag   ()
    );

    // quadrant fold of the azimuth
    assign fa = fl_reg[CL];
    always_comb begin
        case ({fa.x_neg, fa.y_neg})
            2'b00:   azi = t_azim;
            2'b10:   azi = c2s_pkg::ANG_180 - t_azim;
            2'b11:   azi = c2s_pkg::ANG_180 + t_azim;
            default: azi = c2s_pkg::ANG_360 - t_azim;
        endcase
        azc = c2s_pkg::AZ_W'(azi >> c2s_pkg::ANG_SHIFT);
        if (azc > c2s_pkg::AZ_MAX) begin
            azc = c2s_pkg::AZ_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            az_dly[0] <= azc;
            for (int j = 1; j < CL; j++) begin
                az_dly[j] <= az_dly[j-1];
            end
            rng_dly[0] <= rng_raw;
            for (int j = 1; j < RD; j++) begin
                rng_dly[j] <= rng_dly[j-1];
            end
        end
    end

    // output register: sign of elevation, origin forced to zero
    assign fo  = fl_reg[OUT_K];
    assign elc = c2s_pkg::ELEV_W'(t_elev >> c2s_pkg::ANG_SHIFT);

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (fo.origin) begin
                elev_reg <= '0;
                azim_reg <= '0;
            end else begin
                elev_reg <= fo.z_neg ? -elc : elc;
                azim_reg <= az_dly[CL-1];
            end
            rng_reg <= rng_dly[RD-1];
        end
    end

    assign m_valid = mv_reg;
    assign m_elev  = elev_reg;
    assign m_azim  = azim_reg;
    assign m_rng   = rng_reg;

    `C2S_ASSERT_IMP(a_elev_range, aclk, aresetn, mv_reg, (elev_reg <= c2s_pkg::ELEV_LIMIT) && (elev_reg >= -c2s_pkg::ELEV_LIMIT), "elevation out of range")
    `C2S_ASSERT_IMP(a_azim_range, aclk, aresetn, mv_reg, azim_reg <= c2s_pkg::AZ_MAX, "azimuth out of range")
    `C2S_ASSERT_IMP(a_hold_stall, aclk, aresetn, mv_reg && !m_ready, ##1 (mv_reg && $stable(vld_reg[0])), "pipeline moved during stall")
endmodule
`default_nettype wire

// ----- sv/cartesian_to_spherical_point_unit.sv -----
// Top level of the cartesian to spherical point unit.
`default_nettype none
// Converts one lidar point (signed millimetre x, y, z) per beat into elevation and
// azimuth in hundredths of a degree and range in centimetres. The unit takes a new
// point every clock unless an output stall fills the queue; the delay from the input
// beat to m_tvalid is set mostly by the two 26-stage CORDIC vectoring passes
// (azimuth, then elevation against the horizontal distance). The range path
// (squares, one root bit per stage, divide by ten) runs beside them. A four-entry
// queue between the input stage and the pipeline absorbs short output stalls.
module cartesian_to_spherical_point_unit #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // x_mm, y_mm, z_mm (COORD_BITS each), zero pad to bytes
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // elevation_cdeg[14:0], azimuth_cdeg[30:15], range_cm[46:31], zero at [47]
    output logic [47:0]                              m_tdata
);
    localparam int QW = 3*COORD_BITS + c2s_pkg::FLAGS_W;

    logic          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;
    logic signed [c2s_pkg::ELEV_W-1:0] elev;
    logic [c2s_pkg::AZ_W-1:0]          azim;
    logic [c2s_pkg::RNG_W-1:0]         rng;

    c2s_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .x_mm    (s_tdata[COORD_BITS-1:0]),
        .y_mm    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .z_mm    (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    c2s_fifo #(.W(QW)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    c2s_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_elev  (elev),
        .m_azim  (azim),
        .m_rng   (rng)
    );

    assign m_tdata = {1'b0, rng, azim, elev};
endmodule
`default_nettype wire
